FILE: sv/lkv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants, types and codes for the lru key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int ENTRIES = 8;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 4;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CNT_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    localparam int IN_TDATA_W  = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + VAL_W + 1 + KEY_W + KEY_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic {
        OP_PUT = 1'b0,
        OP_GET = 1'b1
    } t_op;

    typedef logic [KEY_W-1:0]        t_key;
    typedef logic signed [VAL_W-1:0] t_value;

    typedef struct packed {
        logic shift;
        logic wr_value;
        logic valid_en;
        logic valid_d;
    } t_cell_ctrl;

    typedef struct packed {
        logic   hit;
        t_value read_value;
        logic   evicted;
        t_key   evicted_key;
        t_key   most_recent_key;
        logic   store_empty;
    } t_result;

endpackage

FILE: sv/lkv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_cell
// One slot of the recency chain: holds a key, a value and a valid mark,
// compares its key with the request and takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module lkv_cell import lkv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_key       i_prev_key,
    input  t_value     i_prev_value,
    input  t_value     i_wr_value,
    input  t_key       i_cmp_key,
    output t_key       o_key,
    output t_value     o_value,
    output logic       o_valid,
    output logic       o_match
);

    t_key   r_key;
    t_value r_value;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.valid_en) begin
            r_valid <= i_ctrl.valid_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end else if (i_ctrl.wr_value) begin
            r_value <= i_wr_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_key == i_cmp_key);

endmodule

FILE: sv/lkv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_ctrl
// Chain controller: capacity register, occupancy count, per-cell shift and
// write enables, and the result of each request.
// ----------------------------------------------------------------------------
module lkv_ctrl import lkv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data,
    input  logic             i_accept,
    input  t_op              i_op,
    input  t_key             i_key,
    input  t_value           i_value,
    input  t_key             i_keys   [ENTRIES],
    input  t_value           i_values [ENTRIES],
    input  logic [ENTRIES-1:0] i_match,
    output t_cell_ctrl       o_ctrl   [ENTRIES],
    output t_key             o_head_key,
    output t_value           o_head_value,
    output t_result          o_result
);

    logic [CAP_W-1:0] r_capacity;
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;

    logic [OCC_W-1:0] cap_eff;
    logic [OCC_W-1:0] base;
    logic             hit_any;
    logic             put_miss;
    logic             put_hit;
    logic             get_hit;
    logic             full;
    t_value           rd_sel;
    t_key             last_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_accept) begin
            r_occ <= n_occ;
        end
    end

    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = OCC_W'(1);
        end else if (CNT_W'(r_capacity) > CNT_W'(ENTRIES)) begin
            cap_eff = OCC_W'(ENTRIES);
        end else begin
            cap_eff = OCC_W'(r_capacity);
        end
    end

    // one-hot selects: the matching cell, and the least recent held cell
    always_comb begin
        rd_sel   = '0;
        last_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_match[i]) begin
                rd_sel = rd_sel | i_values[i];
            end
            if (r_occ == OCC_W'(i + 1)) begin
                last_key = last_key | i_keys[i];
            end
        end
    end

    always_comb begin
        hit_any  = |i_match;
        put_miss = (i_op == OP_PUT) && !hit_any;
        put_hit  = (i_op == OP_PUT) && hit_any;
        get_hit  = (i_op == OP_GET) && hit_any;
        full     = r_occ >= cap_eff;
        base     = (put_miss && full) ? (cap_eff - OCC_W'(1)) : r_occ;
        n_occ    = put_miss ? (base + OCC_W'(1)) : r_occ;

        for (int i = 0; i < ENTRIES; i++) begin
            o_ctrl[i].shift    = i_accept &&
                                 ((put_miss && (OCC_W'(i) <= base)) ||
                                  (get_hit && (|(i_match >> i))));
            o_ctrl[i].wr_value = i_accept && put_hit && i_match[i];
            o_ctrl[i].valid_en = i_accept;
            o_ctrl[i].valid_d  = OCC_W'(i) < n_occ;
        end

        o_head_key   = i_key;
        o_head_value = (i_op == OP_PUT) ? i_value : rd_sel;

        o_result.hit         = hit_any;
        o_result.read_value  = get_hit ? rd_sel : '0;
        o_result.evicted     = put_miss && full;
        o_result.evicted_key = (put_miss && full) ? last_key : '0;
        if (put_miss || get_hit) begin
            o_result.most_recent_key = i_key;
        end else if (r_occ != '0) begin
            o_result.most_recent_key = i_keys[0];
        end else begin
            o_result.most_recent_key = '0;
        end
        o_result.store_empty = n_occ == '0;
    end

`ifndef SYNTH
    // keys in the chain stay unique
    a_match_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_match))
        else $error("more than one cell matches the request key");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(ENTRIES))
        else $error("occupancy beyond the number of cells");

    a_evict_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && put_miss && full) |=> (r_occ == $past(cap_eff)))
        else $error("eviction did not leave the store at capacity");

    a_get_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_op == OP_GET)) |=> (r_occ == $past(r_occ)))
        else $error("get changed occupancy");
`endif

endmodule

FILE: sv/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Key-value store in recency order, built as a shifting chain of cells with
// the most recent entry in cell 0.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  s        in   i_s_tvalid/o_s_tready tuser op, tdata key, value
//  m        out  o_m_tvalid/i_m_tready tdata hit .. store_empty
//  cfg      in   i_cfg_wr_en           i_cfg_wr_data capacity
//
//  one request per cycle: all cells compare in parallel and the chain
//  reorders in the cycle of acceptance; the result is registered in the
//  output register at the same edge. a stalled output holds the result and
//  blocks only further requests. synchronous reset clears valid marks,
//  occupancy and the output valid, and sets capacity to 8.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CAP_W-1:0]       i_cfg_wr_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // key, value
    input  logic                   i_s_tuser,   // op
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // hit, read_value, evicted, evicted_key, most_recent_key, store_empty
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic       accept;
    t_op        req_op;
    t_key       req_key;
    t_value     req_value;

    t_key       cell_key   [ENTRIES];
    t_value     cell_value [ENTRIES];
    logic [ENTRIES-1:0] cell_valid;
    logic [ENTRIES-1:0] cell_match;
    t_cell_ctrl cell_ctrl  [ENTRIES];
    t_key       head_key;
    t_value     head_value;
    t_result    result;

    logic       r_m_valid;
    t_result    r_m_data;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign req_op     = t_op'(i_s_tuser);
    assign req_key    = i_s_tdata[KEY_W-1:0];
    assign req_value  = i_s_tdata[KEY_W+VAL_W-1:KEY_W];

    lkv_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_op          (req_op),
        .i_key         (req_key),
        .i_value       (req_value),
        .i_keys        (cell_key),
        .i_values      (cell_value),
        .i_match       (cell_match),
        .o_ctrl        (cell_ctrl),
        .o_head_key    (head_key),
        .o_head_value  (head_value),
        .o_result      (result)
    );

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_key   prev_key;
        t_value prev_value;

        if (g == 0) begin : g_head
            assign prev_key   = head_key;
            assign prev_value = head_value;
        end else begin : g_link
            assign prev_key   = cell_key[g-1];
            assign prev_value = cell_value[g-1];
        end

        lkv_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl[g]),
            .i_prev_key   (prev_key),
            .i_prev_value (prev_value),
            .i_wr_value   (req_value),
            .i_cmp_key    (req_key),
            .o_key        (cell_key[g]),
            .o_value      (cell_value[g]),
            .o_valid      (cell_valid[g]),
            .o_match      (cell_match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_data <= result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_m_data.store_empty,
                                      r_m_data.most_recent_key,
                                      r_m_data.evicted_key,
                                      r_m_data.evicted,
                                      r_m_data.read_value,
                                      r_m_data.hit});

`ifndef SYNTH
    // valid marks stay packed at the front of the chain
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid & (cell_valid + ENTRIES'(1))) == '0))
        else $error("valid cells are not contiguous from the front");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && cell_valid[0]) |=> !result.store_empty || !r_m_data.store_empty
            || !cell_valid[0])
        else $error("store reported empty while cell 0 is valid");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        result.hit |-> (cell_valid != '0))
        else $error("hit reported with no valid cell");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lru key-value cache. A scoreboard keeps its own
// recency-ordered copy of the store, predicts one result per accepted request
// and compares every returned result field by field. Directed requests cover
// empty store, extreme keys and values, put hits, deep get hits, eviction and
// out-of-range or lowered capacity; random phases then run small key pools
// under many capacity settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import lkv_pkg::*;

    localparam int unsigned LIMIT       = 100000;
    localparam int unsigned QUIET_FROM  = 600;
    localparam int unsigned QUIET_TO    = 1100;
    localparam int unsigned HOLD_AT     = 1400;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int          PHASE_REQS  = 200;

    class cache_scoreboard;
        t_key        held_key[ENTRIES];
        t_value      held_value[ENTRIES];
        int unsigned n_held;
        int unsigned capacity;
        t_result     result_q[$];
        int          errors;

        function new();
            n_held   = 0;
            capacity = CAP_RESET;
            errors   = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        // entry at pos goes to the front, entries above it slide back one
        function void move_to_front(int unsigned pos, t_key key, t_value value);
            for (int unsigned i = pos; i > 0; i--) begin
                held_key[i]   = held_key[i-1];
                held_value[i] = held_value[i-1];
            end
            held_key[0]   = key;
            held_value[0] = value;
        endfunction

        function void note_request(t_op op, t_key key, t_value value);
            t_result     r;
            int          pos;
            int unsigned usable;
            r   = '0;
            pos = -1;
            for (int i = 0; i < n_held; i++) begin
                if (pos < 0 && held_key[i] == key) pos = i;
            end
            usable = (capacity < 1) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
            r.hit = (pos >= 0);
            if (op == OP_PUT) begin
                if (pos >= 0) begin
                    held_value[pos] = value;
                end else begin
                    // a lowered capacity trims the tail in one step
                    if (n_held >= usable) begin
                        r.evicted     = 1'b1;
                        r.evicted_key = held_key[n_held-1];
                        n_held        = usable - 1;
                    end
                    move_to_front(n_held, key, value);
                    n_held++;
                end
            end else if (pos >= 0) begin
                r.read_value = held_value[pos];
                move_to_front(pos, key, held_value[pos]);
            end
            r.most_recent_key = (n_held > 0) ? held_key[0] : '0;
            r.store_empty     = (n_held == 0);
            result_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $error("%s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            t_result want;
            if (result_q.size() == 0) begin
                errors++;
                $error("result with no request waiting");
                return;
            end
            want = result_q.pop_front();
            compare_field("hit",             want.hit,             d[0]);
            compare_field("read_value",      want.read_value,      d[32:1]);
            compare_field("evicted",         want.evicted,         d[33]);
            compare_field("evicted_key",     want.evicted_key,     d[65:34]);
            compare_field("most_recent_key", want.most_recent_key, d[97:66]);
            compare_field("store_empty",     want.store_empty,     d[98]);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]       i_cfg_wr_data = '0;
    logic                   i_s_tvalid    = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata     = '0;  // key, value
    logic                   i_s_tuser     = 1'b0; // op
    logic                   o_m_tvalid;
    logic                   i_m_tready    = 1'b0;
    // hit, read_value, evicted, evicted_key, most_recent_key, store_empty
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    int unsigned     cyc = 0;
    cache_scoreboard sb  = new();
    wire             no_idle = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    lru_key_value_cache dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    // receiver: random stalls, a quiet window, and one long hold-off
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (cyc == HOLD_AT) hold_left = HOLD_CYCLES;
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (no_idle) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 9);
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_request(t_op op, t_key key, t_value value);
        while (!no_idle && $urandom_range(99) < 9) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {value, key};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(op, key, value);
        @(negedge i_clk);
    endtask

    // only written once every outstanding result is back
    task automatic write_capacity(logic [CAP_W-1:0] c);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= c;
        @(posedge i_clk);
        sb.set_capacity(c);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] caps[9];
        t_key             pool[16];
        int               pool_size;
        t_op              op;
        t_key             key;
        t_value           value;

        caps = '{4'd3, 4'd0, 4'd15, 4'd1, 4'd5, 4'd9, 4'd8, 4'd2, 4'd7};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty store, extreme keys and values, put hit, get hit and miss
        send_request(OP_GET, 32'h0, 32'h0);
        send_request(OP_PUT, 32'h0, 32'h8000_0000);
        send_request(OP_PUT, 32'hffff_ffff, 32'h7fff_ffff);
        send_request(OP_PUT, 32'h0, 32'hffff_ffff);
        send_request(OP_GET, 32'h0, 32'h1234_5678);
        send_request(OP_GET, 32'h1234_5678, 32'h5);
        // fill up at reset capacity, then evict
        for (int i = 0; i < 6; i++) send_request(OP_PUT, 32'h100 + i, $urandom);
        send_request(OP_PUT, 32'ha5a5_a5a5, 32'h1);
        send_request(OP_GET, 32'h0, 32'h0);
        // capacity lowered below the number of held entries
        write_capacity(4'd2);
        send_request(OP_GET, 32'h100, 32'h0);
        send_request(OP_PUT, 32'h200, 32'h9);
        send_request(OP_PUT, 32'h201, 32'ha);
        // zero acts as one
        write_capacity(4'd0);
        send_request(OP_PUT, 32'h300, 32'hb);
        send_request(OP_PUT, 32'h301, 32'hc);
        send_request(OP_GET, 32'h300, 32'h0);
        send_request(OP_PUT, 32'h301, 32'hd);
        // above the number of entries acts as the maximum
        write_capacity(4'd15);
        for (int i = 0; i < 3; i++) send_request(OP_PUT, 32'h400 + i, $urandom);

        foreach (caps[p]) begin
            write_capacity(caps[p]);
            pool_size = $urandom_range(14, 3);
            for (int i = 0; i < pool_size; i++) begin
                case ($urandom_range(7))
                    0:       pool[i] = 32'h0;
                    1:       pool[i] = 32'hffff_ffff;
                    default: pool[i] = $urandom;
                endcase
            end
            for (int n = 0; n < PHASE_REQS; n++) begin
                op  = ($urandom_range(99) < 55) ? OP_GET : OP_PUT;
                key = ($urandom_range(99) < 6) ? t_key'($urandom)
                                               : pool[$urandom_range(pool_size - 1)];
                case ($urandom_range(19))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7fff_ffff;
                    default: value = t_value'($urandom);
                endcase
                send_request(op, key, value);
            end
        end

        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
